// ===== design/plp_pkg.sv =====
// Package for the positional list store: command codes, widths and cell control.
`default_nettype none
package plp_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int IN_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT_AT = 3'd1,
    CMD_REM_LAST  = 3'd2,
    CMD_REM_AT    = 3'd3,
    CMD_READ_AT   = 3'd4,
    CMD_READ_LAST = 3'd5
  } cmd_t;

  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [POS_W-1:0] idx;
  } plp_ctl_t;

endpackage
`default_nettype wire

// ===== design/plp_cell.sv =====
// One storage cell of the list: holds one entry and trades it with its neighbors.
`default_nettype none
module plp_cell #(
  parameter int IDX = 0,
  parameter int EW  = 32
) (
  input  wire logic              clk,
  input  wire plp_pkg::plp_ctl_t ctl,
  input  wire logic [EW-1:0]     wdata,
  input  wire logic [EW-1:0]     left_data,
  input  wire logic [EW-1:0]     right_data,
  output logic      [EW-1:0]     entry
);
  import plp_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [EW-1:0] entry_r;
  logic [EW-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_up) begin
      if (MY_IDX == ctl.idx) begin
        entry_nxt = wdata;
      end else if (MY_IDX > ctl.idx) begin
        entry_nxt = left_data;
      end
    end else if (ctl.shift_down) begin
      if (MY_IDX >= ctl.idx) begin
        entry_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

// ===== design/positional_list_store.sv =====
// Top level of the positional list store: command decode, cell row and result register.
// A bounded ordered list of up to CAPACITY entries held in a row of cells. Each request
// carries one command in in_tuser (append, insert at, remove last, remove at, read at,
// read last) and yields exactly one result. All cells shift together in the cycle of acceptance,
// so a new request is taken each cycle while the result register is empty or being drained.
// Refused commands (full, empty, read at out of range, unused codes) set out_tuser and leave
// the list unchanged. No clearing pass after reset.
`default_nettype none
module positional_list_store #(
  parameter int CAPACITY      = plp_pkg::CAPACITY_DEF,
  parameter int ELEMENT_WIDTH = plp_pkg::ELEMENT_WIDTH_DEF,
  localparam int CW           = $clog2(CAPACITY + 1),
  localparam int OUT_TDATA_W  = ((plp_pkg::DATA_W + CW + 1 + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // position, value
  input  wire logic [plp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  wire logic [plp_pkg::CMD_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // data_out, entry_count, is_empty, zero pad
  output logic      [OUT_TDATA_W-1:0]          out_tdata,
  // error
  output logic                                 out_tuser
);
  import plp_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int PAD_W = OUT_TDATA_W - DATA_W - CW - 1;

  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] value;
  cmd_t               cmd;
  logic [EW-1:0]      val_elem;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic          out_err_r;
  logic [CW-1:0] out_count_r;
  logic          out_empty_r;

  logic [EW-1:0] ent [CAPACITY];
  plp_ctl_t      ctl;

  logic          in_fire;
  logic          full, empty, ok, rd_en;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic          pos_ge_cnt, pos_ge_last;
  logic [IW-1:0] pos_idx, cnt_idx, last_idx, rd_idx;
  logic [EW-1:0] rd_elem;
  logic [DATA_W-1:0] rd_data, data_res;

  assign pos   = in_tdata[POS_W-1:0];
  assign value = in_tdata[POS_W+VALUE_W-1:POS_W];
  assign cmd   = cmd_t'(in_tuser);

  generate
    if (EW <= VALUE_W) begin : g_val_narrow
      assign val_elem = value[EW-1:0];
    end else begin : g_val_wide
      assign val_elem = {{(EW-VALUE_W){1'b0}}, value};
    end
    if (EW >= DATA_W) begin : g_rd_wide
      assign rd_data = rd_elem[DATA_W-1:0];
    end else begin : g_rd_narrow
      assign rd_data = {{(DATA_W-EW){1'b0}}, rd_elem};
    end
  endgenerate

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign full       = (count_r == CW'(CAPACITY));
  assign empty      = (count_r == '0);
  assign pos_x      = CMP_W'(pos);
  assign cnt_x      = CMP_W'(count_r);
  assign pos_ge_cnt = (pos_x >= cnt_x);
  assign pos_ge_last = ((pos_x + CMP_W'(1)) >= cnt_x);
  assign pos_idx    = pos[IW-1:0];
  assign cnt_idx    = count_r[IW-1:0];
  assign last_idx   = cnt_idx - IW'(1);

  always_comb begin
    ok             = 1'b0;
    rd_en          = 1'b0;
    rd_idx         = pos_idx;
    count_nxt      = count_r;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.idx        = POS_W'(cnt_idx);
    unique case (cmd)
      CMD_APPEND: begin
        ok           = !full;
        ctl.shift_up = !full;
        count_nxt    = full ? count_r : count_r + CW'(1);
      end
      CMD_INSERT_AT: begin
        ok           = !full;
        ctl.shift_up = !full;
        ctl.idx      = pos_ge_cnt ? POS_W'(cnt_idx) : POS_W'(pos_idx);
        count_nxt    = full ? count_r : count_r + CW'(1);
      end
      CMD_REM_LAST: begin
        ok        = !empty;
        rd_en     = 1'b1;
        rd_idx    = last_idx;
        count_nxt = empty ? count_r : count_r - CW'(1);
      end
      CMD_REM_AT: begin
        ok             = !empty;
        rd_en          = 1'b1;
        rd_idx         = pos_ge_last ? last_idx : pos_idx;
        ctl.idx        = POS_W'(rd_idx);
        ctl.shift_down = !empty;
        count_nxt      = empty ? count_r : count_r - CW'(1);
      end
      CMD_READ_AT: begin
        ok     = !pos_ge_cnt;
        rd_en  = 1'b1;
        rd_idx = pos_idx;
      end
      CMD_READ_LAST: begin
        ok     = !empty;
        rd_en  = 1'b1;
        rd_idx = last_idx;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!in_fire) begin
      ctl.shift_up   = 1'b0;
      ctl.shift_down = 1'b0;
      count_nxt      = count_r;
    end
  end

  assign rd_elem  = ent[rd_idx];
  assign data_res = (ok && rd_en) ? rd_data : '0;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [EW-1:0] left_d, right_d;
      if (i == 0) begin : g_first
        assign left_d = ent[i];
      end else begin : g_left
        assign left_d = ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_d = ent[i];
      end else begin : g_right
        assign right_d = ent[i+1];
      end
      plp_cell #(
        .IDX (i),
        .EW  (EW)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .wdata      (val_elem),
        .left_data  (left_d),
        .right_data (right_d),
        .entry      (ent[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r  <= data_res;
      out_err_r   <= !ok;
      out_count_r <= count_nxt;
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  generate
    if (PAD_W > 0) begin : g_pad
      assign out_tdata = {{PAD_W{1'b0}}, out_empty_r, out_count_r, out_data_r};
    end else begin : g_nopad
      assign out_tdata = {out_empty_r, out_count_r, out_data_r};
    end
  endgenerate

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ok) |=> (count_r == $past(count_r)))
    else $error("refused request changed the count");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r && out_count_r == count_r))
    else $error("result missing or count mismatch");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the positional list store: directed, fill and random command streams with checking.
`timescale 1ns / 100ps
module tb_top;
  import plp_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 1 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              err;
    logic [CNT_W-1:0]  cnt;
    logic              empty;
  } list_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int                shadow_count;
  list_result_t      list_result_q [$];
  int                fail_count;
  int                cycle_count;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                rx_hold_cycles;

  positional_list_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic list_result_t predict_list_command(logic [CMD_W-1:0] cmd,
                                                        logic [POS_W-1:0] pos,
                                                        logic [VALUE_W-1:0] val);
    list_result_t r;
    int           slot;
    int           i;
    bit           ok;
    logic [DATA_W-1:0] word;
    ok   = 1'b0;
    word = '0;
    case (cmd)
      CMD_APPEND, CMD_INSERT_AT: begin
        if (shadow_count < CAPACITY) begin
          slot = (cmd == CMD_APPEND || pos >= shadow_count) ? shadow_count : int'(pos);
          for (i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot] = val;
          shadow_count++;
          ok = 1'b1;
        end
      end
      CMD_REM_LAST, CMD_REM_AT: begin
        if (shadow_count > 0) begin
          slot = (cmd == CMD_REM_LAST || pos >= shadow_count - 1) ? shadow_count - 1
                                                                  : int'(pos);
          word = shadow_entries[slot];
          for (i = slot; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
          ok = 1'b1;
        end
      end
      CMD_READ_AT: begin
        if (pos < shadow_count) begin
          word = shadow_entries[pos];
          ok   = 1'b1;
        end
      end
      CMD_READ_LAST: begin
        if (shadow_count > 0) begin
          word = shadow_entries[shadow_count-1];
          ok   = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
    r.data  = ok ? word : '0;
    r.err   = !ok;
    r.cnt   = shadow_count[CNT_W-1:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] got_v);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, exp_v, got_v, cycle_count);
    fail_count++;
  endtask

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] val);
    list_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = cmd;
    in_tdata  = {val, pos};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    r = predict_list_command(cmd, pos, val);
    list_result_q.push_back(r);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready = 1'b0;
      rx_hold_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (list_result_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_tdata[DATA_W-1:0]);
      end else begin
        e = list_result_q.pop_front();
        if (out_tdata[DATA_W-1:0] !== e.data)
          report_mismatch("data_out", e.data, out_tdata[DATA_W-1:0]);
        if (out_tuser !== e.err)
          report_mismatch("error", DATA_W'(e.err), DATA_W'(out_tuser));
        if (out_tdata[DATA_W+CNT_W-1:DATA_W] !== e.cnt)
          report_mismatch("entry_count", DATA_W'(e.cnt),
                          DATA_W'(out_tdata[DATA_W+CNT_W-1:DATA_W]));
        if (out_tdata[DATA_W+CNT_W] !== e.empty)
          report_mismatch("is_empty", DATA_W'(e.empty), DATA_W'(out_tdata[DATA_W+CNT_W]));
      end
    end
  end

  task automatic test_directed_edges();
    send_request(CMD_REM_LAST, 8'd0, 32'h0);
    send_request(CMD_REM_AT, 8'd0, 32'h0);
    send_request(CMD_READ_LAST, 8'd0, 32'h0);
    send_request(CMD_READ_AT, 8'd0, 32'h0);
    send_request(CMD_UNUSED_A, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED_B, 8'h00, 32'h1234_5678);
    send_request(CMD_APPEND, 8'hFF, 32'h0000_0000);
    send_request(CMD_APPEND, 8'h00, 32'hFFFF_FFFF);
    send_request(CMD_INSERT_AT, 8'hFF, 32'hA5A5_A5A5);
    send_request(CMD_INSERT_AT, 8'd0, 32'h5A5A_5A5A);
    send_request(CMD_INSERT_AT, 8'd1, 32'h8000_0001);
    send_request(CMD_READ_AT, 8'd0, 32'h0);
    send_request(CMD_READ_AT, 8'd4, 32'h0);
    send_request(CMD_READ_AT, 8'd5, 32'h0);
    send_request(CMD_READ_AT, 8'hFF, 32'h0);
    send_request(CMD_READ_LAST, 8'd0, 32'h0);
    send_request(CMD_REM_AT, 8'd1, 32'h0);
    send_request(CMD_REM_AT, 8'hFF, 32'h0);
    send_request(CMD_REM_AT, 8'd3, 32'h0);
    send_request(CMD_REM_LAST, 8'd0, 32'h0);
    send_request(CMD_UNUSED_A, 8'd0, 32'h0);
  endtask

  task automatic test_fill_under_hold();
    rx_hold_cycles = 80;
    while (shadow_count < CAPACITY) send_request(CMD_APPEND, 8'($urandom), $urandom);
    send_request(CMD_APPEND, 8'd0, 32'hDEAD_BEEF);
    send_request(CMD_INSERT_AT, 8'd0, 32'hCAFE_F00D);
    send_request(CMD_INSERT_AT, 8'hFF, 32'h0BAD_0BAD);
    send_request(CMD_READ_AT, 8'(CAPACITY - 1), 32'h0);
    send_request(CMD_READ_AT, 8'(CAPACITY), 32'h0);
    send_request(CMD_REM_AT, 8'd0, 32'h0);
    send_request(CMD_INSERT_AT, 8'd0, 32'h7777_7777);
    send_request(CMD_READ_AT, 8'd0, 32'h0);
    send_request(CMD_READ_LAST, 8'd0, 32'h0);
  endtask

  task automatic test_random_mix(int n_items, int tx_pct, int rx_pct);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    int               roll;
    bit               grow;
    int               k;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    grow = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) grow = $urandom_range(1);
      roll = $urandom_range(99);
      if (roll < 30)      cmd = grow ? CMD_APPEND    : CMD_REM_LAST;
      else if (roll < 55) cmd = grow ? CMD_INSERT_AT : CMD_REM_AT;
      else if (roll < 64) cmd = grow ? CMD_REM_LAST  : CMD_APPEND;
      else if (roll < 73) cmd = grow ? CMD_REM_AT    : CMD_INSERT_AT;
      else if (roll < 85) cmd = CMD_READ_AT;
      else if (roll < 95) cmd = CMD_READ_LAST;
      else if (roll < 97) cmd = CMD_UNUSED_A;
      else                cmd = CMD_UNUSED_B;
      if ($urandom_range(3) == 0) pos = 8'($urandom_range(255));
      else                        pos = 8'($urandom_range(shadow_count + 1));
      send_request(cmd, pos, $urandom);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    shadow_count   = 0;
    tx_idle_pct    = 20;
    rx_idle_pct    = 84;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_fill_under_hold();
    test_random_mix(340, 20, 84);
    test_random_mix(340, 84, 20);
    test_random_mix(350, 0, 0);

    in_tvalid = 1'b0;
    while (list_result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
